// File: src/atlas_rectangle_first_fit_unit_assert.svh
// Assertion macros for the rectangle packer.
`ifndef ATLAS_RECTANGLE_FIRST_FIT_UNIT_ASSERT_SVH
`define ATLAS_RECTANGLE_FIRST_FIT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ARFF_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define ARFF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define ARFF_ASSERT_SAME(label, clk, rst_n, cond, prop, msg)
`define ARFF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// File: src/arff_pkg.sv
package arff_pkg;

    localparam int KEY_SLOTS = 256;
    localparam int ATLAS_MAX = 4096;
    localparam int SLOT_W    = $clog2(KEY_SLOTS);
    localparam int IDX_W     = SLOT_W + 1;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int KEY_W     = 8;

    typedef enum logic [1:0] {
        OP_PLACE,
        OP_REMOVE,
        OP_EVICT,
        OP_NONE
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PL_CHECK,
        ST_ROW,
        ST_CAND,
        ST_SCAN,
        ST_PL_WRITE,
        ST_REMOVE,
        ST_EVICT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic pl_init;
        logic row_init;
        logic scan_start;
        logic scan_run;
        logic take_hit;
        logic next_row;
        logic write_slot;
        logic do_remove;
        logic ev_start;
        logic ev_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic fits;
        logic row_ok;
        logic cand_ok;
        logic have_ystep;
        logic hit;
        logic scan_done;
        logic ev_found;
        logic ev_last;
        logic out_free;
    } sts_t;

endpackage

// File: src/atlas_rectangle_first_fit_unit.sv
// First-fit rectangle packer with one table slot per signed 8-bit key.
// Input words arrive on s_axis: tuser carries the opcode (place, remove,
// evict lowest key) and tdata the key and rectangle size. One result word
// per request leaves on m_axis: tuser is the success flag, tdata holds the
// placed position and the evicted key.
// The atlas size is written through the cfg channel (index 0 width, index 1
// height), which is always ready; values above 4096 saturate.
// Remove clears the key's valid bit; evict checks one valid bit per cycle from
// the lowest slot up. A place visits candidate positions one at a time and,
// for each, reads table entries through one memory read port until an entry
// overlaps the candidate or every entry has been read.
// One request is handled at a time; s_axis_tready is high only when the
// unit is idle.
// The result sits in an output register, so a stalled receiver only holds
// back the next request once that request has finished its own work.
// Reset empties the table and sets the atlas to 1024 by 1024 at once.
module atlas_rectangle_first_fit_unit import arff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // item_key[7:0], rect_width[20:8], rect_height[33:21]
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // place_x[11:0], place_y[23:12], evicted_key[31:24]
    output logic        m_axis_tuser,  // success
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

`include "atlas_rectangle_first_fit_unit_assert.svh"

    cmd_t             cmd;
    sts_t             sts;
    logic             in_fire;
    logic [POS_W-1:0] out_x, out_y;
    logic [KEY_W-1:0] out_key;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    arff_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    arff_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (s_axis_tuser),
        .in_key      (s_axis_tdata[7:0]),
        .in_w        (s_axis_tdata[20:8]),
        .in_h        (s_axis_tdata[33:21]),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_success (m_axis_tuser),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_key     (out_key)
    );

    assign m_axis_tdata = {out_key, out_y, out_x};

    `ARFF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !s_axis_tready, "input accepted while busy")
    `ARFF_ASSERT_NEXT(a_load_shows_word, clk, rst_n, cmd.load_out, m_axis_tvalid, "result word lost")
    `ARFF_ASSERT_SAME(a_hit_not_done, clk, rst_n, sts.hit, !sts.scan_done, "hit and scan end together")

endmodule

// File: src/arff_ctrl.sv
module arff_ctrl import arff_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  sts_t sts,
    output logic in_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                unique case (sts.op)
                    OP_PLACE:  state_next = ST_PL_CHECK;
                    OP_REMOVE: state_next = ST_REMOVE;
                    OP_EVICT:  state_next = ST_EVICT;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_PL_CHECK: state_next = sts.fits ? ST_ROW : ST_FINISH;
            ST_ROW:      state_next = sts.row_ok ? ST_CAND : ST_FINISH;
            ST_CAND:
            begin
                if (sts.cand_ok)
                    state_next = ST_SCAN;
                else if (sts.have_ystep)
                    state_next = ST_ROW;
                else
                    state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (sts.hit)
                    state_next = ST_CAND;
                else if (sts.scan_done)
                    state_next = ST_PL_WRITE;
            end
            ST_PL_WRITE: state_next = ST_FINISH;
            ST_REMOVE:   state_next = ST_FINISH;
            ST_EVICT:
            begin
                if (sts.ev_found || sts.ev_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_fire;
            end
            ST_DECODE:   cmd.ev_start = (sts.op == OP_EVICT);
            ST_PL_CHECK: cmd.pl_init = sts.fits;
            ST_ROW:      cmd.row_init = sts.row_ok;
            ST_CAND:
            begin
                cmd.scan_start = sts.cand_ok;
                cmd.next_row   = !sts.cand_ok && sts.have_ystep;
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.take_hit = sts.hit;
            end
            ST_PL_WRITE: cmd.write_slot = 1'b1;
            ST_REMOVE:   cmd.do_remove = 1'b1;
            ST_EVICT:    cmd.ev_step = 1'b1;
            ST_FINISH:   cmd.load_out = sts.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

// File: src/arff_dp.sv
module arff_dp import arff_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    input  logic [1:0]       in_op,
    input  logic [KEY_W-1:0] in_key,
    input  logic [DIM_W-1:0] in_w,
    input  logic [DIM_W-1:0] in_h,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             out_success,
    output logic [POS_W-1:0] out_x,
    output logic [POS_W-1:0] out_y,
    output logic [KEY_W-1:0] out_key
);

    localparam int ENT_W = 2 * POS_W + 2 * DIM_W;

    logic [DIM_W-1:0]     aw_reg, ah_reg;
    logic [DIM_W-1:0]     cfg_sat;
    logic [1:0]           op_reg;
    logic [KEY_W-1:0]     slot_reg;
    logic [DIM_W-1:0]     w_reg, h_reg;
    logic [DIM_W-1:0]     x_reg, y_reg, ynext_reg;
    logic                 ystep_vld_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 chk_vld_reg;
    logic                 chk_sv_reg;
    logic [SLOT_W-1:0]    chk_idx_reg;
    logic [ENT_W-1:0]     rd_reg;
    logic [ENT_W-1:0]     mem [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] valid_reg;
    logic                 res_success_reg;
    logic [POS_W-1:0]     res_x_reg, res_y_reg;
    logic [KEY_W-1:0]     res_key_reg;
    logic                 out_valid_reg;
    logic                 out_success_reg;
    logic [POS_W-1:0]     out_x_reg, out_y_reg;
    logic [KEY_W-1:0]     out_key_reg;

    logic                 slot_ok;
    logic [SLOT_W-1:0]    addr;
    logic [SLOT_W-1:0]    idx_lo;
    logic [POS_W-1:0]     r_left, r_top;
    logic [DIM_W-1:0]     r_wide, r_tall;
    logic [DIM_W-1:0]     r_right, r_bot;
    logic [DIM_W:0]       x_end, y_end;
    logic                 overlap;
    logic                 hit;
    logic                 idx_in_range;

    assign cfg_sat = (cfg_data > DIM_W'(ATLAS_MAX)) ? DIM_W'(ATLAS_MAX) : cfg_data;

    // Slot index is the key with its sign bit flipped, so slot order is key order.
    assign slot_ok      = {1'b0, slot_reg} < (KEY_W + 1)'(KEY_SLOTS);
    assign addr         = slot_reg[SLOT_W-1:0];
    assign idx_lo       = idx_reg[SLOT_W-1:0];
    assign idx_in_range = idx_reg < IDX_W'(KEY_SLOTS);

    assign {r_left, r_top, r_wide, r_tall} = rd_reg;
    assign r_right = DIM_W'(r_left) + r_wide;
    assign r_bot   = DIM_W'(r_top) + r_tall;
    assign x_end   = {1'b0, x_reg} + {1'b0, w_reg};
    assign y_end   = {1'b0, y_reg} + {1'b0, h_reg};
    assign overlap = (x_reg < r_right) && ((DIM_W + 1)'(r_left) < x_end) &&
                     (y_reg < r_bot) && ((DIM_W + 1)'(r_top) < y_end);
    assign hit     = chk_vld_reg && chk_sv_reg && overlap;

    always_comb
    begin
        sts.op         = op_t'(op_reg);
        sts.fits       = slot_ok && (w_reg <= aw_reg) && (h_reg <= ah_reg);
        sts.row_ok     = y_end <= {1'b0, ah_reg};
        sts.cand_ok    = x_end <= {1'b0, aw_reg};
        sts.have_ystep = ystep_vld_reg;
        sts.hit        = hit;
        sts.scan_done  = chk_vld_reg && !hit && (chk_idx_reg == SLOT_W'(KEY_SLOTS - 1));
        sts.ev_found   = valid_reg[idx_lo];
        sts.ev_last    = idx_lo == SLOT_W'(KEY_SLOTS - 1);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg <= DIM_W'(1024);
            ah_reg <= DIM_W'(1024);
        end
        else if (cfg_we)
        begin
            if (cfg_index == 2'd0)
                aw_reg <= cfg_sat;
            else if (cfg_index == 2'd1)
                ah_reg <= cfg_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= in_op;
            slot_reg <= in_key ^ KEY_W'(8'h80);
            w_reg    <= in_w;
            h_reg    <= in_h;
        end
        if (cmd.pl_init)
            y_reg <= '0;
        else if (cmd.next_row)
            y_reg <= ynext_reg;
        if (cmd.row_init)
            x_reg <= '0;
        else if (cmd.take_hit)
            x_reg <= r_right;
        if (cmd.take_hit && (!ystep_vld_reg || r_bot < ynext_reg))
            ynext_reg <= r_bot;
        chk_idx_reg <= idx_lo;
        chk_sv_reg  <= valid_reg[idx_lo];
        rd_reg      <= mem[idx_lo];
        if (cmd.write_slot)
            mem[addr] <= {x_reg[POS_W-1:0], y_reg[POS_W-1:0], w_reg, h_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ystep_vld_reg <= 1'b0;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.row_init)
                ystep_vld_reg <= 1'b0;
            else if (cmd.take_hit)
                ystep_vld_reg <= 1'b1;
            if (cmd.scan_start || cmd.ev_start)
            begin
                idx_reg     <= '0;
                chk_vld_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                chk_vld_reg <= idx_in_range;
                if (idx_in_range)
                    idx_reg <= idx_reg + 1'b1;
            end
            else if (cmd.ev_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            res_success_reg <= 1'b0;
            res_x_reg       <= '0;
            res_y_reg       <= '0;
            res_key_reg     <= '0;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                res_success_reg <= 1'b0;
                res_x_reg       <= '0;
                res_y_reg       <= '0;
                res_key_reg     <= '0;
            end
            if (cmd.write_slot)
            begin
                valid_reg[addr] <= 1'b1;
                res_success_reg <= 1'b1;
                res_x_reg       <= x_reg[POS_W-1:0];
                res_y_reg       <= y_reg[POS_W-1:0];
            end
            if (cmd.do_remove && slot_ok && valid_reg[addr])
            begin
                valid_reg[addr] <= 1'b0;
                res_success_reg <= 1'b1;
            end
            if (cmd.ev_step && valid_reg[idx_lo])
            begin
                valid_reg[idx_lo] <= 1'b0;
                res_success_reg   <= 1'b1;
                res_key_reg       <= KEY_W'(idx_lo) ^ KEY_W'(8'h80);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_success_reg <= res_success_reg;
            out_x_reg       <= res_x_reg;
            out_y_reg       <= res_y_reg;
            out_key_reg     <= res_key_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_success = out_success_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_key     = out_key_reg;

endmodule
